>>> rtl/lsc_pkg.sv
package lsc_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int ORDER_W       = 5;
    localparam int CELL_W        = 5;
    localparam int SYM_W         = 4;
    localparam int TALLY_W       = 9;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(16);
    localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;

    // classified cell, handed from the front to the back
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             in_range;
        logic             row_end;
        logic             square_end;
    } cls_t;

    typedef struct packed {
        logic               is_valid;
        logic [TALLY_W-1:0] filled;
    } res_t;

endpackage

>>> rtl/lsc_ram.sv
module lsc_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lsc_queue.sv
module lsc_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/lsc_front.sv
module lsc_front
    import lsc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [ORDER_W-1:0]           cfg_wdata,
    input  logic                         push,
    input  logic signed [CELL_W-1:0]     cell_value,
    output logic                         full,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [$clog2(MAX_ORDER)-1:0] q_col,
    output cls_t                         q_cls
);

    localparam int PW = $clog2(MAX_ORDER);
    localparam int CW = ((PW > ORDER_W) ? PW : ORDER_W) + 1;

    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] order_use;
    logic [PW-1:0]      col_reg, col_next;
    logic [PW-1:0]      row_reg, row_next;
    logic               row_end, square_end, in_range;

    // order 0 behaves as 1, anything above MAX_ORDER as MAX_ORDER
    always_comb
    begin
        if (order_reg == '0)
        begin
            order_use = ORDER_W'(1);
        end
        else if (int'(order_reg) > MAX_ORDER)
        begin
            order_use = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            order_use = order_reg;
        end
    end

    assign in_range   = !cell_value[CELL_W-1] &&
                        ({1'b0, cell_value[SYM_W-1:0]} < order_use);
    assign row_end    = (CW'(col_reg) + CW'(1)) >= CW'(order_use);
    assign square_end = row_end && ((CW'(row_reg) + CW'(1)) >= CW'(order_use));

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign q_col  = col_reg;

    always_comb
    begin
        q_cls.symbol     = cell_value[SYM_W-1:0];
        q_cls.in_range   = in_range;
        q_cls.row_end    = row_end;
        q_cls.square_end = square_end;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = square_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                order_reg <= cfg_wdata;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> rtl/lsc_back.sv
module lsc_back
    import lsc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic [$clog2(MAX_ORDER)-1:0] q_col,
    input  cls_t                         q_cls,
    output logic                         q_pop,
    input  logic                         res_full,
    output logic                         res_push,
    output res_t                         res
);

    localparam int PW = $clog2(MAX_ORDER);

    logic                 exe_valid_reg, exe_valid_next;
    cls_t                 exe_cls_reg;
    logic [PW-1:0]        exe_col_reg;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [MAX_ORDER-1:0] fwd_mask_reg;
    logic [MAX_ORDER-1:0] col_valid_reg, col_valid_next;
    logic [MAX_ORDER-1:0] row_seen_reg, row_seen_next;
    logic                 still_reg, still_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;

    logic                 load, fire, wr_en;
    logic [MAX_ORDER-1:0] rd_data, col_cur, col_new, sym_bit;
    logic                 dup, cell_ok;
    logic                 res_valid;
    logic [TALLY_W-1:0]   res_tally;

    // only the last cell of a square waits on the result queue
    assign fire  = exe_valid_reg && (!exe_cls_reg.square_end || !res_full);
    assign load  = !q_empty && (!exe_valid_reg || fire);
    assign q_pop = load;
    assign wr_en = fire && exe_cls_reg.in_range;

    lsc_ram #(
        .WIDTH (MAX_ORDER),
        .DEPTH (MAX_ORDER)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (exe_col_reg),
        .wr_data (col_new),
        .rd_en   (load),
        .rd_addr (q_col),
        .rd_data (rd_data)
    );

    // a read that met a write to the same column takes the written mask
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            col_cur = fwd_mask_reg;
        end
        else if (col_valid_reg[exe_col_reg])
        begin
            col_cur = rd_data;
        end
        else
        begin
            col_cur = '0;
        end
    end

    assign sym_bit = MAX_ORDER'(1) << exe_cls_reg.symbol;
    assign col_new = col_cur | sym_bit;
    assign dup     = ((row_seen_reg & sym_bit) != '0) || ((col_cur & sym_bit) != '0);
    assign cell_ok = exe_cls_reg.in_range && !dup;

    always_comb
    begin
        res_valid = still_reg && cell_ok;
        res_tally = tally_reg;
        if (exe_cls_reg.in_range && (tally_reg != TALLY_MAX))
        begin
            res_tally = tally_reg + 1'b1;
        end
    end

    assign res_push     = fire && exe_cls_reg.square_end;
    assign res.is_valid = res_valid;
    assign res.filled   = res_tally;

    always_comb
    begin
        exe_valid_next = exe_valid_reg;
        if (load)
        begin
            exe_valid_next = 1'b1;
        end
        else if (fire)
        begin
            exe_valid_next = 1'b0;
        end

        // held while a stalled cell sits in the execute stage
        fwd_hit_next = load ? (wr_en && !exe_cls_reg.square_end && (q_col == exe_col_reg))
                            : fwd_hit_reg;

        col_valid_next = col_valid_reg;
        row_seen_next  = row_seen_reg;
        still_next     = still_reg;
        tally_next     = tally_reg;
        if (fire)
        begin
            if (exe_cls_reg.square_end)
            begin
                col_valid_next = '0;
                row_seen_next  = '0;
                still_next     = 1'b1;
                tally_next     = '0;
            end
            else
            begin
                if (wr_en)
                begin
                    col_valid_next[exe_col_reg] = 1'b1;
                end
                row_seen_next = exe_cls_reg.row_end ? '0 :
                                (exe_cls_reg.in_range ? (row_seen_reg | sym_bit) : row_seen_reg);
                still_next    = res_valid;
                tally_next    = res_tally;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            col_valid_reg <= '0;
            row_seen_reg  <= '0;
            still_reg     <= 1'b1;
            tally_reg     <= '0;
        end
        else
        begin
            exe_valid_reg <= exe_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            col_valid_reg <= col_valid_next;
            row_seen_reg  <= row_seen_next;
            still_reg     <= still_next;
            tally_reg     <= tally_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            exe_cls_reg  <= q_cls;
            exe_col_reg  <= q_col;
            fwd_mask_reg <= col_new;
        end
    end

endmodule

>>> rtl/latin_square_checker.sv
// Channel   Direction  Handshake            Payload
// cell      in         push / full          cell_value (5b signed)
// result    out        empty / pop          square_is_valid (1b), filled_cells (9b)
// config    in         cfg_wen              cfg_wdata (5b, square order)
//
// One cell per cycle sustained while the result queue has room; the column mask
// memory is read once and written at most once per cell. The result of a square
// passes the cell queue, the execute stage and the result queue. rst_n clears all
// control state at once; column masks are invalidated by per-column valid bits,
// so there is no clearing pass. A full result queue stalls only the last cell of
// a square; a two-entry queue keeps accepting cells behind it.
module latin_square_checker
    import lsc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wen,
    input  logic [ORDER_W-1:0]       cfg_wdata,
    input  logic                     push,
    output logic                     full,
    input  logic signed [CELL_W-1:0] cell_value,
    output logic                     empty,
    input  logic                     pop,
    output logic                     square_is_valid,
    output logic [TALLY_W-1:0]       filled_cells
);

    localparam int PW    = $clog2(MAX_ORDER);
    localparam int REC_W = PW + $bits(cls_t);

    logic             q_full, q_push, q_empty, q_pop;
    logic [PW-1:0]    f_col, h_col;
    cls_t             f_cls, h_cls;
    logic [REC_W-1:0] q_rdata;
    logic             res_full, res_push;
    res_t             res_in, res_out;
    logic [$bits(res_t)-1:0] res_rdata;

    lsc_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .cell_value (cell_value),
        .full       (full),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_col      (f_col),
        .q_cls      (f_cls)
    );

    lsc_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cell_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_col, f_cls}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {h_col, h_cls} = q_rdata;

    lsc_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_col    (h_col),
        .q_cls    (h_cls),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res_in)
    );

    lsc_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out         = res_rdata;
    assign square_is_valid = res_out.is_valid;
    assign filled_cells    = res_out.filled;

endmodule

>>> rtl/lsc_checker.sv
module lsc_checker
    import lsc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     push,
    input logic                     full,
    input logic                     empty,
    input logic                     pop,
    input logic                     square_is_valid,
    input logic [TALLY_W-1:0]       filled_cells
);

    // out of reset the result queue is empty and the cell queue is not full
    a_reset_idle: assert property (@(posedge clk) !rst_n ##1 !rst_n |-> empty && !full)
        else $error("queues not drained in reset");

    // a valid square has at least one filled cell
    a_valid_filled: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && square_is_valid |-> filled_cells != '0)
        else $error("valid square reported with no filled cells");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(square_is_valid) && $stable(filled_cells))
        else $error("waiting result changed");

    // the cell queue only fills on a request
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

endmodule

bind latin_square_checker lsc_checker u_lsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .square_is_valid (square_is_valid),
    .filled_cells    (filled_cells)
);
